[hdl/udiv32_pkg.sv]
package udiv32_pkg;

  // Default operand width of the divider.
  localparam int unsigned DEF_WIDTH = 32;

endpackage

[hdl/udiv32_in_if.sv]
interface udiv32_in_if #(
  parameter int unsigned WIDTH = udiv32_pkg::DEF_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] dividend;
  logic [WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

[hdl/udiv32_out_if.sv]
interface udiv32_out_if #(
  parameter int unsigned WIDTH = udiv32_pkg::DEF_WIDTH
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] quotient;
  logic [WIDTH-1:0] remainder;
  logic             divide_by_zero;

  modport source (output valid, output quotient, output remainder, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                  output ready);
endinterface

[hdl/udiv32_cell.sv]
module udiv32_cell #(
  parameter int unsigned WIDTH = udiv32_pkg::DEF_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] den_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] num_o,
  output logic [WIDTH-1:0] den_o
);

  logic             valid_q;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] num_q, num_d;
  logic [WIDTH-1:0] den_q;
  logic [WIDTH:0]   part;
  logic [WIDTH:0]   diff;
  logic             take;

  // One restoring step. The partial remainder is one bit wider than the
  // operands, so a bit shifted out of the top still counts in the compare.
  always_comb begin
    part  = {rem_i, num_i[WIDTH-1]};
    diff  = part - {1'b0, den_i};
    take  = ~diff[WIDTH];
    rem_d = take ? diff[WIDTH-1:0] : part[WIDTH-1:0];
    // The dividend leaves at the top while quotient bits enter at the bottom.
    num_d = {num_i[WIDTH-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      den_q <= den_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

[hdl/unsigned_divide_32.sv]
// Unsigned restoring divider.
//
// Items arrive on the in_i channel (dividend, divisor) and leave on the
// out_o channel (quotient, remainder, divide_by_zero), both with valid/ready
// handshakes; an item moves at a rising edge where valid and ready are high.
// A divisor of zero gives quotient and remainder of zero with divide_by_zero set.
//
// The datapath is a row of WIDTH identical cells, one per quotient bit, from
// the most significant bit down. Each cell does one shift, compare and
// conditional subtract and registers the result. An item passes through the
// registers of all WIDTH cells in order, and its result is offered from the
// register of the last cell. The row takes one new item every cycle unless
// it is full and the receiver stalls.
//
// When the receiver stalls, the last cell and the unbroken run of full cells
// behind it hold, while the other cells keep moving up and filling, so input
// stays ready until the whole row is full. Reset clears all cell valid flags;
// the row is empty and ready right after reset.
module unsigned_divide_32 #(
  parameter int unsigned WIDTH = udiv32_pkg::DEF_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  udiv32_in_if.sink    in_i,
  udiv32_out_if.source out_o
);

  // Pipeline links: index k is what enters cell k, index WIDTH is the output.
  logic             valid_s [WIDTH+1];
  logic [WIDTH-1:0] rem_s   [WIDTH+1];
  logic [WIDTH-1:0] num_s   [WIDTH+1];
  logic [WIDTH-1:0] den_s   [WIDTH+1];
  // A cell loads when it is empty or the cell after it moves on.
  logic             en_s    [WIDTH+1];

  assign valid_s[0] = in_i.valid;
  assign rem_s[0]   = '0;
  assign num_s[0]   = in_i.dividend;
  assign den_s[0]   = in_i.divisor;

  assign en_s[WIDTH] = out_o.ready;

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    assign en_s[k] = ~valid_s[k+1] | en_s[k+1];

    udiv32_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_s[k]),
      .valid_i (valid_s[k]),
      .rem_i   (rem_s[k]),
      .num_i   (num_s[k]),
      .den_i   (den_s[k]),
      .valid_o (valid_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .num_o   (num_s[k+1]),
      .den_o   (den_s[k+1])
    );
  end

  assign in_i.ready = en_s[0];

  // The divisor travels with its item, so a zero divisor is spotted at the
  // end of the row and the result fields are forced to zero there.
  logic div_zero;
  assign div_zero = (den_s[WIDTH] == '0);

  assign out_o.valid          = valid_s[WIDTH];
  assign out_o.quotient       = div_zero ? '0 : num_s[WIDTH];
  assign out_o.remainder      = div_zero ? '0 : rem_s[WIDTH];
  assign out_o.divide_by_zero = div_zero;

endmodule

[hdl/udiv32_checker.sv]
module udiv32_checker #(
  parameter int unsigned WIDTH = udiv32_pkg::DEF_WIDTH
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [WIDTH-1:0] quotient_i,
  input logic [WIDTH-1:0] remainder_i,
  input logic             divide_by_zero_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A zero divisor yields zero quotient and remainder.
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && divide_by_zero_i |-> quotient_i == '0 && remainder_i == '0)
    else $error("nonzero fields on divide by zero");

  // With no result waiting, the row cannot be full.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while output empty");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid after reset");

  // Nothing is offered at the first edge after reset is released.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid on reset release");

endmodule

bind unsigned_divide_32 udiv32_checker #(
  .WIDTH (WIDTH)
) u_udiv32_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .quotient_i       (out_o.quotient),
  .remainder_i      (out_o.remainder),
  .divide_by_zero_i (out_o.divide_by_zero)
);

[test/tb_unsigned_divide_32.sv]
module tb_unsigned_divide_32;

  import udiv32_pkg::*;

  localparam int unsigned WIDTH = DEF_WIDTH;

  // The divider row is WIDTH cells deep, and a result passes through every cell before it shows up.
  // The drain wait at the end is longer than the trip of an item through the row.
  localparam int unsigned DRAIN_CYCLES = WIDTH + 16;

  // The watchdog trips when the quiet count on both channels reaches QUIET_LIMIT.
  // The longest quiet stretch in a correct run comes from the forced receiver
  // hold-off of HOLD_OFF_CYCLES.
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned QUIET_LIMIT     = 2000;

  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
  } division_t;

  logic clk_i;
  logic rst_ni;

  udiv32_in_if  #(.WIDTH(WIDTH)) in_if ();
  udiv32_out_if #(.WIDTH(WIDTH)) out_if ();

  unsigned_divide_32 #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Results that are still owed by the divider, oldest first.
  division_t pending_quotients[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Sender idling. burst_left counts the items left in the current burst.
  // gaps_enabled lets the back-pressure test send back to back.
  int unsigned burst_left   = 0;
  bit          gaps_enabled = 1'b1;

  // The back-pressure test sets this to request a long receiver hold-off. The
  // receiver process picks it up and counts the stall down itself.
  int unsigned hold_off_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Restoring division, written out bit by bit. The partial remainder carries one
  // bit above WIDTH. This makes the compare exact even when the shift carries out
  // of the word. This is how a large divisor near 2**WIDTH still gives the right result.
  function automatic division_t divide_restoring(word_t dividend, word_t divisor);
    division_t       res;
    logic [WIDTH:0]  partial;
    res = '0;
    if (divisor == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    partial = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      partial = {partial[WIDTH-1:0], dividend[i]};
      if (partial >= {1'b0, divisor}) begin
        partial         = partial - {1'b0, divisor};
        res.quotient[i] = 1'b1;
      end
    end
    res.remainder = partial[WIDTH-1:0];
    return res;
  endfunction

  // Offer one item and hold it until the divider takes it. Handshake signals are
  // sampled at the falling edge. Both sides drive at the rising edge, so the
  // values seen there are the ones that the next rising edge acts on. The
  // expected result is queued as soon as acceptance is certain.
  task automatic send_division(word_t dividend, word_t divisor);
    bit taken;
    if (gaps_enabled && burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      // Now and then a long burst, so that some stretches run with no gaps.
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
    end
    in_if.valid    <= 1'b1;
    in_if.dividend <= dividend;
    in_if.divisor  <= divisor;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      if (taken) pending_quotients.push_back(divide_restoring(dividend, divisor));
      @(posedge clk_i);
    end while (!taken);
    if (burst_left != 0) burst_left--;
  endtask

  task automatic report_mismatch(string what, division_t want, division_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected q=%h r=%h dbz=%b, got q=%h r=%h dbz=%b", $realtime, what,
               want.quotient, want.remainder, want.divide_by_zero,
               got.quotient, got.remainder, got.divide_by_zero);
    end
  endtask

  // Each result that the receiver takes is compared with the oldest one still owed.
  always @(negedge clk_i) begin : result_check
    division_t got;
    division_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.quotient, out_if.remainder, out_if.divide_by_zero};
      if (pending_quotients.size() == 0) begin
        report_mismatch("result with no item pending", '0, got);
      end else begin
        want = pending_quotients.pop_front();
        if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
            got.divide_by_zero !== want.divide_by_zero) begin
          report_mismatch("wrong result", want, got);
        end
      end
    end
  end

  // The watchdog counts cycles in which nothing moves on either channel.
  always @(negedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_unsigned_divide_32 failed");
      $finish;
    end
  end

  // The receiver works in phases of random length. Each phase has its own stall
  // rate, from never stalling to stalling most of the time. A pending hold-off
  // request overrides the pattern and keeps ready low for the requested count.
  initial begin : result_sink
    int unsigned phase_len;
    int unsigned stall_pct;
    int unsigned hold;
    out_if.ready <= 1'b0;
    forever begin
      phase_len = $urandom_range(64, 8);
      case ($urandom_range(3, 0))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (phase_len) begin
        @(posedge clk_i);
        if (hold_off_request != 0) begin
          hold             = hold_off_request;
          hold_off_request = 0;
          out_if.ready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
        out_if.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Operand extremes and the cases where the restoring steps are most likely to
  // go wrong: a divisor near the top of the range, a result of one, and equal operands.
  task automatic test_operand_extremes();
    send_division('0, 32'h1);
    send_division('1, 32'h1);
    send_division('1, '1);
    send_division('0, '1);
    send_division(32'h1, '1);
    send_division('1, 32'h2);
    send_division(32'h8000_0000, 32'h3);
    send_division('1, 32'h8000_0000);
    send_division('1, 32'hFFFF_FFFE);
    send_division(32'hFFFF_FFFE, '1);
    send_division(32'h7FFF_FFFF, 32'h8000_0000);
    send_division(32'hC000_0001, 32'h8000_0001);
    send_division(32'h1234_5678, 32'h1234);
    send_division(32'hDEAD_BEEF, 32'hDEAD_BEEF);
    send_division(32'h0000_0005, 32'h0000_0007);
    send_division(32'hAAAA_AAAA, 32'h5555_5555);
    send_division(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // A zero divisor must raise the flag and zero both quotient and remainder, for
  // any dividend.
  task automatic test_divide_by_zero();
    send_division('0, '0);
    send_division('1, '0);
    send_division(32'h8000_0000, '0);
    send_division(32'h0000_0001, '0);
    send_division($urandom, '0);
  endtask

  // Random operand pairs with mixed shapes. Each kind of pair drives the
  // restoring loop in its own way: full-width operands, small divisors that give
  // long quotients, narrow operands, powers of two, dividends below the divisor,
  // divisors with the top bit set, and an occasional zero divisor.
  task automatic test_random_operands(int unsigned count);
    word_t       a;
    word_t       b;
    int unsigned shift;
    repeat (count) begin
      a = $urandom;
      b = $urandom;
      case ($urandom_range(9, 0))
        3: b = $urandom_range(255, 1);
        4: b = b >> $urandom_range(WIDTH - 1, 0);
        5: begin
          b = b | 32'h1;
          a = $urandom_range(b - 1, 0);
        end
        6: b = word_t'(1) << $urandom_range(WIDTH - 1, 0);
        7: begin
          shift = $urandom_range(WIDTH - 1, 0);
          a = a >> shift;
          b = b >> $urandom_range(WIDTH - 1, shift);
        end
        8: begin
          a = a | 32'h8000_0000;
          b = b | 32'h8000_0000;
        end
        9: b = $urandom_range(1, 0) ? '0 : a;
        default: ;
      endcase
      send_division(a, b);
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming back to
  // back. The row fills up and must stall its input. No result may be lost or
  // reordered when the hold is released.
  task automatic test_output_backpressure(int unsigned count);
    gaps_enabled     = 1'b0;
    hold_off_request = HOLD_OFF_CYCLES;
    repeat (count) send_division($urandom, $urandom >> $urandom_range(WIDTH - 1, 0));
    gaps_enabled = 1'b1;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.dividend <= '0;
    in_if.divisor  <= '0;
    repeat (7) @(posedge clk_i);
    // Reset is released away from the rising edge, so that no flop sees it change
    // at the same moment as the clock.
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operand_extremes();
    test_divide_by_zero();
    test_random_operands(330);
    test_output_backpressure(120);
    test_random_operands(330);

    in_if.valid <= 1'b0;
    // Wait for every owed result. The watchdog covers a divider that never finishes.
    while (pending_quotients.size() != 0) @(posedge clk_i);
    // Give any stray result time to appear before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_unsigned_divide_32 passed");
    end else begin
      $display("tb_unsigned_divide_32 failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/udiv32_pkg.sv
hdl/udiv32_in_if.sv
hdl/udiv32_out_if.sv
hdl/udiv32_cell.sv
hdl/unsigned_divide_32.sv
hdl/udiv32_checker.sv
test/tb_unsigned_divide_32.sv
